// File: src/bsrf_pkg.sv
`timescale 1ns / 1ps

package bsrf_pkg;

    localparam int NUM_ROWS_DEF  = 1024;
    localparam int ROW_WORDS_DEF = 4;
    localparam int WORD_BITS_DEF = 64;

    localparam int CMD_W      = 2;
    localparam int ROW_IDX_W  = 10;
    localparam int WORD_IDX_W = 2;
    localparam int DATA_W     = 64;
    localparam int COUNT_W    = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROW_WRITE   = 2'd0,
        CMD_QUERY_WRITE = 2'd1,
        CMD_FILTER      = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [ROW_IDX_W-1:0]  row_index;
        logic [WORD_IDX_W-1:0] word_index;
        logic [DATA_W-1:0]     word_data;
        logic                  last_in_list;
    } t_in_item;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] tested_index;
        logic                 is_kept;
        logic                 list_done;
        logic [COUNT_W-1:0]   kept_count;
    } t_out_item;

    // one verdict handed to the kept counter
    typedef struct packed {
        logic update;
        logic kept;
        logic last;
    } t_tally_cmd;

endpackage

// File: src/bsrf_ifs.sv
`timescale 1ns / 1ps

interface bsrf_in_if;
    import bsrf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bsrf_out_if;
    import bsrf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/bsrf_tally.sv
`timescale 1ns / 1ps

module bsrf_tally #(
    parameter int NUM_ROWS = bsrf_pkg::NUM_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bsrf_pkg::t_tally_cmd         i_cmd,
    output logic [bsrf_pkg::COUNT_W-1:0] o_next_count
);
    import bsrf_pkg::*;

    localparam int CNT_W = $clog2(NUM_ROWS + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] count_inc;

    // saturates at the row count
    always_comb begin
        count_inc = r_count;
        if (i_cmd.kept && (r_count < CNT_W'(NUM_ROWS))) begin
            count_inc = r_count + 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.update) begin
            n_count = i_cmd.last ? '0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_next_count = COUNT_W'(count_inc);

endmodule

// File: src/bitset_subset_row_filter_unit.sv
`timescale 1ns / 1ps
// load items (row word, query word) give no result.
// a filter item walks its row: one row word and one query word are read
// per cycle from the two single-port memories, and the walk stops at the first violating word.
// the result is registered.
// synchronous active-low reset clears the sequencer state, the output valid flag and the kept count;
// the row and query memories are not cleared and hold nothing meaningful until written.

module bitset_subset_row_filter_unit #(
    parameter int NUM_ROWS  = bsrf_pkg::NUM_ROWS_DEF,
    parameter int ROW_WORDS = bsrf_pkg::ROW_WORDS_DEF,
    parameter int WORD_BITS = bsrf_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsrf_in_if.sink     i_in,
    bsrf_out_if.source  o_out
);
    import bsrf_pkg::*;

    localparam int MEM_DEPTH = NUM_ROWS * ROW_WORDS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int QAW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [WORD_BITS-1:0] r_row_mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] r_qry_mem [ROW_WORDS];
    logic [WORD_BITS-1:0] r_row_q;
    logic [WORD_BITS-1:0] r_qry_q;

    logic [MEM_AW-1:0]    r_addr, n_addr;
    logic [QAW-1:0]       r_word, n_word;
    logic                 r_row_ok, n_row_ok;
    logic [ROW_IDX_W-1:0] r_index, n_index;
    logic                 r_last, n_last;
    logic                 r_kept, n_kept;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 accept;
    logic                 in_row_ok;
    logic                 in_word_ok;
    logic [MEM_AW-1:0]    base_addr;
    logic [MEM_AW-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 row_we;
    logic                 qry_we;
    logic                 rd_en;
    logic [MEM_AW-1:0]    row_rd_addr;
    logic [QAW-1:0]       qry_rd_addr;
    logic                 last_word;
    logic                 violation;
    logic                 finish;
    logic                 slot_free;
    logic                 emit;
    logic                 emit_kept;
    t_tally_cmd           tally_cmd;
    logic [COUNT_W-1:0]   next_count;

    // one item at a time, so a read never overlaps a write to the same entry
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign in_row_ok  = int'(i_in.payload.row_index) < NUM_ROWS;
    assign in_word_ok = int'(i_in.payload.word_index) < ROW_WORDS;
    assign base_addr  = MEM_AW'(int'(i_in.payload.row_index) * ROW_WORDS);
    assign wr_addr    = base_addr + MEM_AW'(i_in.payload.word_index);
    assign wr_data    = WORD_BITS'(i_in.payload.word_data);

    assign row_we = accept && (i_in.payload.command == CMD_ROW_WRITE) && in_row_ok && in_word_ok;
    assign qry_we = accept && (i_in.payload.command == CMD_QUERY_WRITE) && in_word_ok;

    assign last_word = (r_word == QAW'(ROW_WORDS - 1));
    // row_ok gates the compare so that the word read for a row past the table never decides the verdict
    assign violation = r_row_ok && (|(r_row_q & ~r_qry_q));
    assign finish    = (r_state == S_CHECK) && (violation || last_word || !r_row_ok);

    // first word is read straight from the accepted item, the rest from the walk address
    assign rd_en = (accept && (i_in.payload.command == CMD_FILTER))
                || ((r_state == S_CHECK) && !finish);
    assign row_rd_addr = (r_state == S_IDLE) ? base_addr : r_addr;
    assign qry_rd_addr = (r_state == S_IDLE) ? '0 : QAW'(r_word + 1'b1);

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_row_q <= r_row_mem[row_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_we) begin
            r_qry_mem[QAW'(i_in.payload.word_index)] <= wr_data;
        end
        if (rd_en) begin
            r_qry_q <= r_qry_mem[qry_rd_addr];
        end
    end

    assign slot_free = !r_out_valid || o_out.ready;
    assign emit      = ((r_state == S_CHECK) && finish && slot_free)
                    || ((r_state == S_EMIT) && slot_free);
    assign emit_kept = (r_state == S_EMIT) ? r_kept : (r_row_ok && !violation);

    assign tally_cmd.update = emit;
    assign tally_cmd.kept   = emit_kept;
    assign tally_cmd.last   = r_last;

    bsrf_tally #(
        .NUM_ROWS (NUM_ROWS)
    ) u_tally (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (tally_cmd),
        .o_next_count (next_count)
    );

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_word   = r_word;
        n_row_ok = r_row_ok;
        n_index  = r_index;
        n_last   = r_last;
        n_kept   = r_kept;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.payload.command == CMD_FILTER)) begin
                    n_state  = S_CHECK;
                    n_addr   = base_addr + 1'b1;
                    n_word   = '0;
                    n_row_ok = in_row_ok;
                    n_index  = i_in.payload.row_index;
                    n_last   = i_in.payload.last_in_list;
                end
            end
            S_CHECK: begin
                if (finish) begin
                    n_kept  = r_row_ok && !violation;
                    n_state = slot_free ? S_IDLE : S_EMIT;
                end else begin
                    n_addr = r_addr + 1'b1;
                    n_word = r_word + 1'b1;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid        = 1'b1;
            n_out.tested_index = r_index;
            n_out.is_kept      = emit_kept;
            n_out.list_done    = r_last;
            n_out.kept_count   = next_count;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_word   <= n_word;
        r_row_ok <= n_row_ok;
        r_index  <= n_index;
        r_last   <= n_last;
        r_kept   <= n_kept;
        r_out    <= n_out;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_filter_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.payload.command == CMD_FILTER)) |=> (r_state == S_CHECK))
        else $error("filter item did not start a row walk");

    a_word_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_word <= QAW'(ROW_WORDS - 1)))
        else $error("row walk ran past the last word");

    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) != S_IDLE))
        else $error("result appeared without a filter in progress");

endmodule

// File: tb/bsrf_checker.sv
`timescale 1ns / 1ps

module bsrf_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bsrf_in_if   i_req,
    bsrf_out_if  i_rsp,
    output int   o_mismatches,
    output int   o_outstanding
);
    import bsrf_pkg::*;

    localparam int ROWS  = NUM_ROWS_DEF;
    localparam int WORDS = ROW_WORDS_DEF;
    localparam int BITS  = WORD_BITS_DEF;

    logic [BITS-1:0]    table_words [ROWS*WORDS];
    logic [BITS-1:0]    query_words [WORDS];
    logic [COUNT_W-1:0] list_tally;
    t_out_item          verdicts [$];
    int                 faults = 0;

    assign o_mismatches = faults;

    task automatic flag(input string what, input longint unsigned want,
                        input longint unsigned got);
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        faults++;
    endtask

    // updates the table, query and tally; queues the verdict of a filter item
    function automatic void apply_item(input t_in_item it);
        t_out_item res;
        logic      kept;
        int        base;
        base = int'(it.row_index) * WORDS;
        case (it.command)
            CMD_ROW_WRITE: begin
                if (int'(it.row_index) < ROWS && int'(it.word_index) < WORDS)
                    table_words[base + it.word_index] = it.word_data[BITS-1:0];
            end
            CMD_QUERY_WRITE: begin
                if (int'(it.word_index) < WORDS)
                    query_words[it.word_index] = it.word_data[BITS-1:0];
            end
            CMD_FILTER: begin
                kept = int'(it.row_index) < ROWS;
                for (int w = 0; w < WORDS && kept; w++)
                    if ((table_words[base + w] & ~query_words[w]) != '0)
                        kept = 1'b0;
                if (kept && list_tally < ROWS)
                    list_tally++;
                res.tested_index = it.row_index;
                res.is_kept      = kept;
                res.list_done    = it.last_in_list;
                res.kept_count   = list_tally;
                verdicts.push_back(res);
                if (it.last_in_list)
                    list_tally = '0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            verdicts.delete();
            list_tally = '0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                if (verdicts.size() == 0) begin
                    $display("%0t: unexpected result index %0d kept %0b done %0b count %0d",
                             $time, got.tested_index, got.is_kept, got.list_done,
                             got.kept_count);
                    faults++;
                end else begin
                    want = verdicts.pop_front();
                    if (got.tested_index !== want.tested_index)
                        flag("tested_index", want.tested_index, got.tested_index);
                    if (got.is_kept !== want.is_kept)
                        flag("is_kept", want.is_kept, got.is_kept);
                    if (got.list_done !== want.list_done)
                        flag("list_done", want.list_done, got.list_done);
                    if (got.kept_count !== want.kept_count)
                        flag("kept_count", want.kept_count, got.kept_count);
                end
            end
            if (i_req.valid && i_req.ready)
                apply_item(i_req.payload);
        end
        o_outstanding <= verdicts.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bsrf_pkg::*;

    localparam int ROWS  = NUM_ROWS_DEF;
    localparam int WORDS = ROW_WORDS_DEF;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_ITEMS  = 400;
    localparam int LONG_LIST_LEN = 120;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RECENT_DEPTH  = 8;

    typedef enum {FILL_INSIDE, FILL_STRAY, FILL_NOISE} t_fill;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsrf_in_if  req_if ();
    bsrf_out_if rsp_if ();

    int          mismatches;
    int          outstanding;
    bit          calm;
    int unsigned stall_left;
    int          counted;
    bit          paused;

    bit   [WORDS-1:0]  row_fill [ROWS];
    logic [DATA_W-1:0] query_copy [WORDS];
    int                full_rows [$];
    int                recent [$];

    bitset_subset_row_filter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    bsrf_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3ms;
        $display("FAIL bitset_subset_row_filter_unit");
        $finish;
    end

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(16, 0);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int pick_row();
        if (recent.size() > 0 && $urandom_range(4, 0) < 3)
            return recent[$urandom_range(recent.size() - 1, 0)];
        return full_rows[$urandom_range(full_rows.size() - 1, 0)];
    endfunction

    // result side: after every accepted item ready drops for a randomly drawn stall, unless calm draws none
    always @(posedge i_clk) begin : result_sink
        int unsigned hold;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (rsp_if.valid && rsp_if.ready) begin
            hold = draw_gap();
            rsp_if.ready <= (hold == 0);
            stall_left   <= hold;
        end else if (stall_left > 0) begin
            rsp_if.ready <= (stall_left == 1);
            stall_left   <= stall_left - 1;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic put(input logic [CMD_W-1:0] cmd, input int row, input int word,
                       input logic [DATA_W-1:0] data, input logic last);
        t_in_item    it;
        int unsigned gap;
        it.command      = cmd;
        it.row_index    = ROW_IDX_W'(row);
        it.word_index   = WORD_IDX_W'(word);
        it.word_data    = data;
        it.last_in_list = last;
        // track which rows are complete so no filter reads an unwritten word
        if (cmd == CMD_ROW_WRITE && row_fill[row] != '1) begin
            row_fill[row][word] = 1'b1;
            if (row_fill[row] == '1)
                full_rows.push_back(row);
        end else if (cmd == CMD_QUERY_WRITE) begin
            query_copy[word] = data;
        end
        if (cmd != CMD_SPARE)
            counted++;
        gap = draw_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= it;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic write_row(input int row, input t_fill how);
        int                stray_word;
        int                pos;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] gaps;
        stray_word = $urandom_range(WORDS - 1, 0);
        for (int w = 0; w < WORDS; w++) begin
            data = rand_word() & rand_word() & query_copy[w];
            if (how == FILL_NOISE) begin
                data = rand_word();
            end else if (how == FILL_STRAY && w == stray_word) begin
                // one bit that the query lacks, when it lacks any
                gaps = ~query_copy[w];
                if (gaps != '0) begin
                    do pos = $urandom_range(DATA_W - 1, 0); while (!gaps[pos]);
                    data[pos] = 1'b1;
                end
            end
            put(CMD_ROW_WRITE, row, w, data, 1'($urandom_range(1, 0)));
        end
        recent.push_back(row);
        if (recent.size() > RECENT_DEPTH)
            void'(recent.pop_front());
    endtask

    task automatic run_list(input int len);
        t_fill how;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9, 0) == 0)
                put(CMD_SPARE, $urandom_range(ROWS - 1, 0), $urandom_range(WORDS - 1, 0),
                    rand_word(), 1'($urandom_range(1, 0)));
            if ($urandom_range(11, 0) == 0) begin
                how = t_fill'($urandom_range(2, 0));
                write_row(pick_row(), how);
            end
            put(CMD_FILTER, pick_row(), $urandom_range(WORDS - 1, 0), rand_word(),
                i == len - 1);
        end
    endtask

    initial begin : stimulus
        int    sel;
        t_fill how;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        calm    = 1'b0;
        paused  = 1'b0;
        counted = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // query words at the extremes and two alternating patterns
        put(CMD_QUERY_WRITE, 0, 0, '1, 1'b0);
        put(CMD_QUERY_WRITE, ROWS - 1, 1, '0, 1'b1);
        put(CMD_QUERY_WRITE, 0, 2, {32{2'b10}}, 1'b0);
        put(CMD_QUERY_WRITE, 0, 3, {32{2'b01}}, 1'b0);
        // empty row, row equal to the query, row failing on its last word only
        for (int w = 0; w < WORDS; w++)
            put(CMD_ROW_WRITE, 0, w, '0, 1'b0);
        for (int w = 0; w < WORDS; w++)
            put(CMD_ROW_WRITE, ROWS - 1, w, query_copy[w], 1'b1);
        for (int w = 0; w < WORDS; w++)
            put(CMD_ROW_WRITE, ROWS / 2, w, (w == WORDS - 1) ? '1 : '0, 1'b0);
        put(CMD_FILTER, 0, 0, '0, 1'b0);
        put(CMD_FILTER, ROWS - 1, WORDS - 1, '1, 1'b0);
        put(CMD_SPARE, ROWS - 1, WORDS - 1, '1, 1'b1);
        put(CMD_FILTER, ROWS / 2, 0, '0, 1'b0);
        // load in the middle of a list must leave the tally alone
        put(CMD_ROW_WRITE, ROWS / 2, WORDS - 1, '0, 1'b1);
        put(CMD_FILTER, ROWS / 2, 1, '0, 1'b1);
        put(CMD_FILTER, ROWS - 1, 2, '0, 1'b1);

        // one long list of kept rows to run the tally well up
        calm = 1'b1;
        for (int i = 0; i < LONG_LIST_LEN; i++)
            put(CMD_FILTER, 0, $urandom_range(WORDS - 1, 0), rand_word(),
                i == LONG_LIST_LEN - 1);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        calm = 1'b0;

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(7, 0) == 0)
                calm = ~calm;
            sel = $urandom_range(9, 0);
            case (sel)
                0: begin
                    // fresh dense query so that subset rows stay common
                    for (int w = 0; w < WORDS; w++)
                        put(CMD_QUERY_WRITE, $urandom_range(ROWS - 1, 0), w,
                            rand_word() | rand_word() | rand_word(),
                            1'($urandom_range(1, 0)));
                end
                1: put(CMD_QUERY_WRITE, $urandom_range(ROWS - 1, 0),
                       $urandom_range(WORDS - 1, 0), rand_word() | rand_word(),
                       1'($urandom_range(1, 0)));
                2, 3, 4: begin
                    sel = $urandom_range(9, 0);
                    how = (sel < 5) ? FILL_INSIDE : (sel < 8) ? FILL_STRAY : FILL_NOISE;
                    write_row($urandom_range(ROWS - 1, 0), how);
                end
                9: put(CMD_SPARE, $urandom_range(ROWS - 1, 0), $urandom_range(WORDS - 1, 0),
                       rand_word(), 1'($urandom_range(1, 0)));
                default: begin
                    write_row($urandom_range(ROWS - 1, 0),
                              ($urandom_range(3, 0) == 0) ? FILL_STRAY : FILL_INSIDE);
                    run_list($urandom_range(8, 1));
                end
            endcase
            if (!paused && counted > RANDOM_ITEMS / 2) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                wait (outstanding == 0);
                paused = 1'b1;
            end
        end

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        for (int k = 0; k < DRAIN_LIMIT && outstanding != 0; k++)
            @(posedge i_clk);
        repeat (WORDS + 4) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS bitset_subset_row_filter_unit");
        else
            $display("FAIL bitset_subset_row_filter_unit");
        $finish;
    end

endmodule

// File: sim.f
src/bsrf_pkg.sv
src/bsrf_ifs.sv
src/bsrf_tally.sv
src/bitset_subset_row_filter_unit.sv
tb/bsrf_checker.sv
tb/tb.sv
